### hdl/ppmhp_pkg.sv
package ppmhp_pkg;

    // Parse phases of the header and data sequencer.
    typedef enum logic [2:0] {
        PH_LETTER  = 3'd0,
        PH_TYPE    = 3'd1,
        PH_SPACE   = 3'd2,
        PH_WIDTH   = 3'd3,
        PH_HEIGHT  = 3'd4,
        PH_MAXVAL  = 3'd5,
        PH_DATA    = 3'd6,
        PH_IDLE    = 3'd7
    } t_phase;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_MAGIC     = 2'd0;
    localparam logic [1:0] ERR_MAXVAL    = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;
    localparam logic [1:0] ERR_DIMENSION = 2'd3;

    localparam logic [1:0] BPP_GRAY  = 2'd1;
    localparam logic [1:0] BPP_COLOR = 2'd2;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam int MAXVAL_OK = 255;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  pixel;
        logic [15:0] width;
        logic [15:0] height;
        logic [1:0]  bpp;
        logic [1:0]  err;
        logic        last;
    } t_result;

endpackage

### hdl/ppmhp_num_acc.sv
module ppmhp_num_acc import ppmhp_pkg::*; #(
    parameter int DIM_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_active,
    input  logic              i_clear,
    input  logic [7:0]        i_byte,
    output logic              o_term,
    output logic [DIM_BITS:0] o_value
);

    localparam int AW = DIM_BITS + 1;
    localparam int PW = AW + 4;
    localparam logic [AW-1:0] SAT = {1'b1, {DIM_BITS{1'b0}}};

    logic [AW-1:0] r_acc;
    logic [AW-1:0] n_acc;
    logic          r_comment;
    logic          n_comment;
    logic          is_digit;
    logic [3:0]    digit;
    logic [PW-1:0] prod;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit    = 4'(i_byte - CH_ZERO);
    assign prod     = (PW'(r_acc) << 3) + (PW'(r_acc) << 1) + PW'(digit);

    // A number ends at the first byte outside a comment that is neither a digit nor a comment start.
    assign o_term  = i_active && !r_comment && (i_byte != CH_HASH) && !is_digit;
    assign o_value = r_acc;

    always_comb begin
        n_acc     = r_acc;
        n_comment = r_comment;
        if (i_clear) begin
            n_acc     = '0;
            n_comment = 1'b0;
        end else if (i_active) begin
            if (r_comment) begin
                if (i_byte == CH_LF) begin
                    n_comment = 1'b0;
                end
            end else if (i_byte == CH_HASH) begin
                n_comment = 1'b1;
            end else if (is_digit) begin
                // Saturate so that any oversized value stays oversized.
                n_acc = (prod > PW'(SAT)) ? SAT : prod[AW-1:0];
            end else begin
                n_acc = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_comment <= 1'b0;
        end else if (i_step) begin
            r_acc     <= n_acc;
            r_comment <= n_comment;
        end
    end

endmodule

### hdl/ppmhp_core.sv
module ppmhp_core import ppmhp_pkg::*; #(
    parameter int DIM_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    output t_result    o_res
);

    localparam int AREA_W = 2 * DIM_BITS;
    localparam int REM_W  = 2 * DIM_BITS + 1;

    t_phase              r_phase;
    t_phase              n_phase;
    logic                r_color;
    logic [DIM_BITS-1:0] r_width;
    logic [DIM_BITS-1:0] r_height;
    logic [AREA_W-1:0]   r_area;
    logic [REM_W-1:0]    r_remaining;
    logic [REM_W-1:0]    rem_dec;
    logic                num_active;
    logic                num_clear;
    logic                num_term;
    logic [DIM_BITS:0]   num_value;
    logic                space_ok;
    logic                dim_big;
    logic                maxval_ok;

    assign num_active = !i_eos &&
        ((r_phase == PH_WIDTH) || (r_phase == PH_HEIGHT) || (r_phase == PH_MAXVAL));
    assign num_clear  = i_eos || (r_phase == PH_SPACE);
    assign space_ok   = (i_byte == CH_LF) || (i_byte == CH_CR) ||
                        (i_byte == CH_TAB) || (i_byte == CH_SPACE);
    assign dim_big    = num_value[DIM_BITS];
    assign maxval_ok  = (num_value == (DIM_BITS + 1)'(MAXVAL_OK));
    assign rem_dec    = (r_remaining != '0) ? r_remaining - 1'b1 : r_remaining;

    ppmhp_num_acc #(
        .DIM_BITS (DIM_BITS)
    ) u_num_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (i_step),
        .i_active (num_active),
        .i_clear  (num_clear),
        .i_byte   (i_byte),
        .o_term   (num_term),
        .o_value  (num_value)
    );

    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            if (i_eos) begin
                n_phase = PH_LETTER;
            end else begin
                unique case (r_phase)
                    PH_LETTER: n_phase = (i_byte == CH_P) ? PH_TYPE : PH_IDLE;
                    PH_TYPE: begin
                        n_phase = ((i_byte == CH_FIVE) || (i_byte == CH_SIX)) ?
                                  PH_SPACE : PH_IDLE;
                    end
                    PH_SPACE: n_phase = space_ok ? PH_WIDTH : PH_IDLE;
                    PH_WIDTH: begin
                        if (num_term) begin
                            n_phase = dim_big ? PH_IDLE : PH_HEIGHT;
                        end
                    end
                    PH_HEIGHT: begin
                        if (num_term) begin
                            n_phase = dim_big ? PH_IDLE : PH_MAXVAL;
                        end
                    end
                    PH_MAXVAL: begin
                        if (num_term) begin
                            n_phase = (maxval_ok && (r_area != '0)) ? PH_DATA : PH_IDLE;
                        end
                    end
                    PH_DATA: n_phase = (rem_dec == '0) ? PH_IDLE : PH_DATA;
                    PH_IDLE: n_phase = PH_IDLE;
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        o_res = '0;
        if (i_step) begin
            if (i_eos) begin
                unique case (r_phase)
                    PH_TYPE, PH_SPACE: begin
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_ERROR;
                        o_res.err   = ERR_MAGIC;
                    end
                    PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_ERROR;
                        o_res.err   = ERR_TRUNCATED;
                    end
                    PH_DATA: begin
                        o_res.valid = (r_remaining != '0);
                        o_res.kind  = o_res.valid ? KIND_ERROR : KIND_HEADER;
                        o_res.err   = o_res.valid ? ERR_TRUNCATED : ERR_MAGIC;
                    end
                    default: o_res = '0;
                endcase
            end else begin
                unique case (r_phase)
                    PH_LETTER: begin
                        o_res.valid = (i_byte != CH_P);
                        o_res.kind  = o_res.valid ? KIND_ERROR : KIND_HEADER;
                        o_res.err   = ERR_MAGIC;
                    end
                    PH_TYPE: begin
                        o_res.valid = (i_byte != CH_FIVE) && (i_byte != CH_SIX);
                        o_res.kind  = o_res.valid ? KIND_ERROR : KIND_HEADER;
                        o_res.err   = ERR_MAGIC;
                    end
                    PH_SPACE: begin
                        o_res.valid = !space_ok;
                        o_res.kind  = o_res.valid ? KIND_ERROR : KIND_HEADER;
                        o_res.err   = ERR_MAGIC;
                    end
                    PH_WIDTH, PH_HEIGHT: begin
                        if (num_term && dim_big) begin
                            o_res.valid = 1'b1;
                            o_res.kind  = KIND_ERROR;
                            o_res.err   = ERR_DIMENSION;
                        end
                    end
                    PH_MAXVAL: begin
                        if (num_term) begin
                            o_res.valid = 1'b1;
                            if (!maxval_ok) begin
                                o_res.kind = KIND_ERROR;
                                o_res.err  = ERR_MAXVAL;
                            end else begin
                                o_res.kind   = KIND_HEADER;
                                o_res.width  = 16'(r_width);
                                o_res.height = 16'(r_height);
                                o_res.bpp    = r_color ? BPP_COLOR : BPP_GRAY;
                                o_res.last   = (r_area == '0);
                            end
                        end
                    end
                    PH_DATA: begin
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_PIXEL;
                        o_res.pixel = i_byte;
                        o_res.last  = (rem_dec == '0);
                    end
                    default: o_res = '0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LETTER;
        end else begin
            r_phase <= n_phase;
        end
    end

    // The area product is registered when the height closes, ahead of its use when the maxval closes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color     <= 1'b0;
            r_width     <= '0;
            r_height    <= '0;
            r_area      <= '0;
            r_remaining <= '0;
        end else if (i_step) begin
            if (i_eos) begin
                r_color     <= 1'b0;
                r_remaining <= '0;
            end else begin
                if (r_phase == PH_TYPE) begin
                    r_color <= (i_byte == CH_SIX);
                end
                if ((r_phase == PH_WIDTH) && num_term) begin
                    r_width <= num_value[DIM_BITS-1:0];
                end
                if ((r_phase == PH_HEIGHT) && num_term) begin
                    r_height <= num_value[DIM_BITS-1:0];
                    r_area   <= r_width * num_value[DIM_BITS-1:0];
                end
                if ((r_phase == PH_MAXVAL) && num_term && maxval_ok) begin
                    r_remaining <= r_color ? {r_area, 1'b0} : {1'b0, r_area};
                end
                if (r_phase == PH_DATA) begin
                    r_remaining <= rem_dec;
                end
            end
        end
    end

endmodule

### hdl/ppm_stream_header_parser.sv
// A result is presented from the result register after its request has passed the input
// register; a stalled result ahead of it holds the result register.
// Throughput: one request per cycle while no held result stalls the output; the width times height
// product is formed and registered when the height number closes.
// Reset is synchronous and active low; it returns the parser to waiting for
// the letter P and empties the input and result registers.
module ppm_stream_header_parser import ppmhp_pkg::*; #(
    parameter int DIM_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_end_of_stream,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_pixel_byte,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic [1:0]  o_bytes_per_pixel,
    output logic [1:0]  o_error_code,
    output logic        o_last_item
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eos;
    logic       r_out_valid;
    t_result    r_out;
    t_result    res;
    logic       advance;
    logic       step;

    // The input register moves on whenever the result register is free or draining.
    assign advance = !r_out_valid || !i_stall;
    assign step    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    ppmhp_core #(
        .DIM_BITS (DIM_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_eos   (r_in_eos),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_stream_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_result_kind     = r_out.kind;
    assign o_pixel_byte      = r_out.pixel;
    assign o_image_width     = r_out.width;
    assign o_image_height    = r_out.height;
    assign o_bytes_per_pixel = r_out.bpp;
    assign o_error_code      = r_out.err;
    assign o_last_item       = r_out.last;

`ifndef SYNTHESIS
    a_held_request_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("held request dropped from the input register");

    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && (o_result_kind == KIND_PIXEL) && o_last_item) |=> !o_valid)
        else $error("result right after the last data byte");

    a_header_bpp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind == KIND_HEADER)) |->
        ((o_bytes_per_pixel == BPP_GRAY) || (o_bytes_per_pixel == BPP_COLOR)))
        else $error("header result with bad bytes per pixel");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ppmhp_pkg::*;

    localparam int DIM_BITS  = 16;
    localparam int DIM_LIMIT = (1 << DIM_BITS) - 1;
    localparam int ITEM_GOAL = 2000;
    localparam t_result NO_RESULT = '0;

    typedef struct {
        logic [7:0] b;
        logic       eos;
        bit         typed;
        t_result    want;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_stream_byte = 8'h00;
    logic        i_end_of_stream = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_pixel_byte;
    logic [15:0] o_image_width;
    logic [15:0] o_image_height;
    logic [1:0]  o_bytes_per_pixel;
    logic [1:0]  o_error_code;
    logic        o_last_item;

    ppm_stream_header_parser #(.DIM_BITS(DIM_BITS)) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_stream_byte     (i_stream_byte),
        .i_end_of_stream   (i_end_of_stream),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_result_kind     (o_result_kind),
        .o_pixel_byte      (o_pixel_byte),
        .o_image_width     (o_image_width),
        .o_image_height    (o_image_height),
        .o_bytes_per_pixel (o_bytes_per_pixel),
        .o_error_code      (o_error_code),
        .o_last_item       (o_last_item)
    );

    always #5 i_clk = ~i_clk;

    t_request plan[$];
    t_request pending_requests[$];
    t_result  expected_results[$];
    bit       failed = 1'b0;
    int       live_requests = 0;
    bit       tx_quiet = 1'b0;
    bit       rx_quiet = 1'b0;
    int       rx_cycles = 0;
    int       stall_left = 0;

    // Parser state as the predictor sees it.
    t_phase   ph = PH_LETTER;
    bit       in_note = 1'b0;
    bit       is_color = 1'b0;
    int       num_acc = 0;
    int       width_q = 0;
    int       height_q = 0;
    longint   bytes_owed = 0;

    function automatic t_result err_res(logic [1:0] code);
        t_result r;
        r = '0;
        r.valid = 1'b1;
        r.kind = KIND_ERROR;
        r.err = code;
        return r;
    endfunction

    function automatic t_result hdr_res(int w, int h, logic [1:0] bpp, logic last);
        t_result r;
        r = '0;
        r.valid = 1'b1;
        r.kind = KIND_HEADER;
        r.width = 16'(w);
        r.height = 16'(h);
        r.bpp = bpp;
        r.last = last;
        return r;
    endfunction

    task automatic clear_parser();
        ph = PH_LETTER;
        in_note = 1'b0;
        is_color = 1'b0;
        num_acc = 0;
        width_q = 0;
        height_q = 0;
        bytes_owed = 0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eos, output t_result r);
        int         v;
        logic [1:0] bpp;
        r = '0;
        if (eos) begin
            if (ph == PH_TYPE || ph == PH_SPACE) begin
                r = err_res(ERR_MAGIC);
            end else if (ph >= PH_WIDTH && ph <= PH_MAXVAL) begin
                r = err_res(ERR_TRUNCATED);
            end else if (ph == PH_DATA && bytes_owed != 0) begin
                r = err_res(ERR_TRUNCATED);
            end
            clear_parser();
            return;
        end
        case (ph)
            PH_LETTER: begin
                if (b == CH_P) begin
                    ph = PH_TYPE;
                end else begin
                    ph = PH_IDLE;
                    r = err_res(ERR_MAGIC);
                end
            end
            PH_TYPE: begin
                if (b == CH_FIVE || b == CH_SIX) begin
                    is_color = (b == CH_SIX);
                    ph = PH_SPACE;
                end else begin
                    ph = PH_IDLE;
                    r = err_res(ERR_MAGIC);
                end
            end
            PH_SPACE: begin
                if (b == CH_LF || b == CH_CR || b == CH_TAB || b == CH_SPACE) begin
                    ph = PH_WIDTH;
                    num_acc = 0;
                    in_note = 1'b0;
                end else begin
                    ph = PH_IDLE;
                    r = err_res(ERR_MAGIC);
                end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                if (in_note) begin
                    if (b == CH_LF) in_note = 1'b0;
                end else if (b == CH_HASH) begin
                    in_note = 1'b1;
                end else if (b >= CH_ZERO && b <= CH_NINE) begin
                    // The accumulator saturates one above the largest dimension.
                    num_acc = num_acc * 10 + int'(b - CH_ZERO);
                    if (num_acc > DIM_LIMIT + 1) num_acc = DIM_LIMIT + 1;
                end else begin
                    v = num_acc;
                    num_acc = 0;
                    if (ph != PH_MAXVAL) begin
                        if (v > DIM_LIMIT) begin
                            ph = PH_IDLE;
                            r = err_res(ERR_DIMENSION);
                        end else if (ph == PH_WIDTH) begin
                            width_q = v;
                            ph = PH_HEIGHT;
                        end else begin
                            height_q = v;
                            ph = PH_MAXVAL;
                        end
                    end else if (v != MAXVAL_OK) begin
                        ph = PH_IDLE;
                        r = err_res(ERR_MAXVAL);
                    end else begin
                        bpp = is_color ? BPP_COLOR : BPP_GRAY;
                        bytes_owed = longint'(width_q) * longint'(height_q) * longint'(bpp);
                        r = hdr_res(width_q, height_q, bpp, bytes_owed == 0);
                        ph = (bytes_owed == 0) ? PH_IDLE : PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                r.valid = 1'b1;
                r.kind = KIND_PIXEL;
                r.pixel = b;
                if (bytes_owed != 0) bytes_owed--;
                if (bytes_owed == 0) begin
                    r.last = 1'b1;
                    ph = PH_IDLE;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1'b1;
        end
    endtask

    // Predicts on every accepted request and checks every accepted result.
    always @(posedge i_clk) begin : monitor
        t_request req;
        t_result  pred;
        t_result  want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                req = pending_requests.pop_front();
                if (!(ph == PH_IDLE || (i_end_of_stream && ph == PH_LETTER)))
                    live_requests++;
                parse_byte(i_stream_byte, i_end_of_stream, pred);
                want = req.typed ? req.want : pred;
                if (want.valid) expected_results.push_back(want);
            end
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result_kind: no result expected, got %0d", o_result_kind);
                    failed = 1'b1;
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_kind", want.kind, o_result_kind);
                    check_field("pixel_byte", want.pixel, o_pixel_byte);
                    check_field("image_width", want.width, o_image_width);
                    check_field("image_height", want.height, o_image_height);
                    check_field("bytes_per_pixel", want.bpp, o_bytes_per_pixel);
                    check_field("error_code", want.err, o_error_code);
                    check_field("last_item", want.last, o_last_item);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    always @(negedge i_clk) begin
        rx_cycles++;
        if (rx_cycles % 256 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
        if (rx_quiet) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            stall_left = pick_gap();
            i_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic eos = 1'b0,
                              input bit typed = 1'b0, input t_result want = '0);
        t_request req;
        req.b = b;
        req.eos = eos;
        req.typed = typed;
        req.want = want;
        plan.push_back(req);
    endtask

    task automatic send_request(input t_request req);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pending_requests.push_back(req);
        i_valid <= 1'b1;
        i_stream_byte <= req.b;
        i_end_of_stream <= req.eos;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_plan();
        foreach (plan[i]) send_request(plan[i]);
        plan.delete();
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 3))
            0: return CH_LF;
            1: return CH_CR;
            2: return CH_TAB;
            default: return CH_SPACE;
        endcase
    endfunction

    task automatic queue_note();
        logic [7:0] b;
        queue_byte(CH_HASH);
        repeat ($urandom_range(0, 4)) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
            queue_byte(b);
        end
        queue_byte(CH_LF);
    endtask

    task automatic queue_number(int v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 15) == 0) queue_note();
        if ($urandom_range(0, 7) == 0) queue_byte(CH_ZERO);
        for (int i = 0; i < s.len(); i++) begin
            queue_byte(s[i]);
            if ($urandom_range(0, 19) == 0) queue_note();
        end
    endtask

    task automatic queue_separator();
        logic [7:0] b;
        if ($urandom_range(0, 3) != 0) begin
            queue_byte(pick_space());
        end else begin
            do b = 8'($urandom_range(0, 255));
            while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_HASH);
            queue_byte(b);
        end
    endtask

    task automatic queue_file();
        int         r;
        int         w;
        int         h;
        int         maxval;
        bit         color;
        longint     n;
        int         head_len;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            color = 1'($urandom_range(0, 1));
            queue_byte(CH_P);
            queue_byte(color ? CH_SIX : CH_FIVE);
            queue_byte(pick_space());
            r = $urandom_range(0, 99);
            if (r < 80) begin
                w = $urandom_range(0, 6);
                h = $urandom_range(0, 6);
            end else if (r < 88) begin
                w = $urandom_range(0, 16);
                h = $urandom_range(1, 4);
            end else if (r < 94) begin
                // Wide headers with an empty image reach the top bits cheaply.
                w = ($urandom_range(0, 3) == 0) ? DIM_LIMIT : $urandom_range(0, DIM_LIMIT);
                h = 0;
            end else begin
                w = $urandom_range(DIM_LIMIT + 1, 2000000);
                h = $urandom_range(0, 6);
            end
            if ($urandom_range(0, 1) == 0) begin
                r = w;
                w = h;
                h = r;
            end
            case ($urandom_range(0, 14))
                0: maxval = 0;
                1: maxval = 254;
                2: maxval = 256;
                3: maxval = DIM_LIMIT + 1;
                4: maxval = $urandom_range(70000, 9999999);
                default: maxval = MAXVAL_OK;
            endcase
            queue_number(w);
            queue_separator();
            queue_number(h);
            queue_separator();
            queue_number(maxval);
            queue_separator();
            head_len = plan.size();
            if ($urandom_range(0, 11) == 0) begin
                // Stream ends somewhere inside the header.
                r = $urandom_range(1, head_len - 1);
                while (plan.size() > r) plan.delete(plan.size() - 1);
            end else begin
                n = 0;
                if (w <= DIM_LIMIT && h <= DIM_LIMIT && maxval == MAXVAL_OK)
                    n = longint'(w) * h * (color ? 2 : 1);
                if (n > 0 && $urandom_range(0, 4) == 0) n = $urandom_range(0, int'(n) - 1);
                else n = n + $urandom_range(0, 2);
                repeat (int'(n)) queue_byte(8'($urandom_range(0, 255)));
            end
        end else if (r < 93) begin
            case ($urandom_range(0, 2))
                0: begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_P);
                    queue_byte(b);
                end
                1: begin
                    queue_byte(CH_P);
                    do b = 8'($urandom_range(0, 255)); while (b == CH_FIVE || b == CH_SIX);
                    queue_byte(b);
                end
                default: begin
                    queue_byte(CH_P);
                    queue_byte($urandom_range(0, 1) ? CH_SIX : CH_FIVE);
                    do b = 8'($urandom_range(0, 255));
                    while (b == CH_LF || b == CH_CR || b == CH_TAB || b == CH_SPACE);
                    queue_byte(b);
                end
            endcase
            repeat ($urandom_range(0, 3)) queue_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 12))
                queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
        if ($urandom_range(0, 19) != 0) queue_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: magic, an empty-height color image, a width that
        // overflows, and end of stream in the letter, type and number phases.
        queue_byte(8'h00, 1'b1, 1'b1, NO_RESULT);
        queue_byte(8'hFF, 1'b0, 1'b1, err_res(ERR_MAGIC));
        queue_byte(8'hFF, 1'b1, 1'b1, NO_RESULT);
        queue_byte(CH_P);
        queue_byte(CH_SIX);
        queue_byte(CH_LF);
        queue_byte(CH_ZERO + 8'd1);
        queue_byte(CH_SPACE);
        queue_byte(CH_SPACE);
        queue_byte(CH_ZERO + 8'd2);
        queue_byte(CH_ZERO + 8'd5);
        queue_byte(CH_ZERO + 8'd5);
        queue_byte(CH_CR, 1'b0, 1'b1, hdr_res(1, 0, BPP_COLOR, 1'b1));
        queue_byte(8'h41, 1'b0, 1'b1, NO_RESULT);
        queue_byte(8'h00, 1'b1, 1'b1, NO_RESULT);
        queue_byte(CH_P);
        queue_byte(CH_FIVE);
        queue_byte(CH_TAB);
        queue_byte(CH_ZERO + 8'd7);
        repeat (4) queue_byte(CH_ZERO);
        queue_byte(CH_SPACE, 1'b0, 1'b1, err_res(ERR_DIMENSION));
        queue_byte(8'h00, 1'b1, 1'b1, NO_RESULT);
        queue_byte(CH_P);
        queue_byte(CH_ZERO, 1'b1, 1'b1, err_res(ERR_MAGIC));
        queue_byte(CH_P);
        queue_byte(CH_FIVE);
        queue_byte(CH_SPACE);
        queue_byte(CH_ZERO + 8'd3);
        queue_byte(8'hFF, 1'b1, 1'b1, err_res(ERR_TRUNCATED));
        send_plan();

        while (live_requests < ITEM_GOAL) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            queue_file();
            send_plan();
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (pending_requests.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (!failed && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
hdl/ppmhp_pkg.sv
hdl/ppmhp_num_acc.sv
hdl/ppmhp_core.sv
hdl/ppm_stream_header_parser.sv
test/testbench.sv
